/* rtl/quaternion_to_euler_angles_assert.svh */
// Assertion macros shared by the checker
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// condition holds at every edge out of reset
`define Q2E_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent at the next edge, out of reset
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// same, also checked while reset is high
`define Q2E_ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/q2e_pkg.sv */
`default_nettype none
package q2e_pkg;

   localparam int QuatW     = 16;
   localparam int SumW      = 34;
   localparam int LaneW     = 37;
   localparam int AngW      = 35;
   localparam int SqNW      = 58;
   localparam int SqRemW    = 32;
   localparam int SqRootW   = 29;
   localparam int SqrtSteps = 29;
   localparam int MagW      = 28;
   localparam int AtanEntries = 20;
   localparam int RollW     = 15;
   localparam int PitchW    = 14;
   localparam int OutW      = 16;

   localparam logic signed [AngW-1:0] PiS30   = 35'sd3373259426;
   localparam logic signed [SumW-1:0] OneS28  = 34'sd268435456;
   localparam logic signed [OutW-1:0] AngleMax = 16'sd12868;
   localparam logic signed [OutW-1:0] HalfPiQ12 = 16'sd6434;

   typedef struct packed {
      logic signed [LaneW-1:0] x;
      logic signed [LaneW-1:0] y;
      logic signed [AngW-1:0]  z;
   } q2e_lane_type;

   typedef struct packed {
      logic                   valid;
      logic signed [SumW-1:0] sr;
      logic signed [SumW-1:0] cr;
      logic signed [SumW-1:0] sp;
      logic signed [SumW-1:0] sy;
      logic signed [SumW-1:0] cy;
      logic                   clamped;
      logic [SqNW-1:0]        n;
      logic [SqRemW-1:0]      rem;
      logic [SqRootW-1:0]     root;
   } q2e_sq_type;

   typedef struct packed {
      logic         valid;
      q2e_lane_type roll;
      q2e_lane_type pitch;
      q2e_lane_type yaw;
      logic         roll_zero;
      logic         yaw_zero;
      logic         clamped;
      logic         pitch_neg;
   } q2e_cd_type;

   function automatic logic signed [AngW-1:0] q2e_atan(input int idx);
      logic signed [AngW-1:0] r;
      case (idx)
         0:  r = 35'sd843314856;
         1:  r = 35'sd497837829;
         2:  r = 35'sd263043836;
         3:  r = 35'sd133525158;
         4:  r = 35'sd67021686;
         5:  r = 35'sd33543515;
         6:  r = 35'sd16775850;
         7:  r = 35'sd8388437;
         8:  r = 35'sd4194282;
         9:  r = 35'sd2097149;
         10: r = 35'sd1048575;
         11: r = 35'sd524287;
         12: r = 35'sd262143;
         13: r = 35'sd131071;
         14: r = 35'sd65535;
         15: r = 35'sd32767;
         16: r = 35'sd16383;
         17: r = 35'sd8191;
         18: r = 35'sd4095;
         19: r = 35'sd2047;
         default: r = '0;
      endcase
      return r;
   endfunction

   // fold the left half-plane onto the right one
   function automatic q2e_lane_type q2e_prerotate(input logic signed [SumW-1:0] y,
                                                  input logic signed [SumW-1:0] x);
      q2e_lane_type l;
      logic signed [LaneW-1:0] xe;
      logic signed [LaneW-1:0] ye;
      xe = LaneW'(x);
      ye = LaneW'(y);
      if (x < 0) begin
         l.x = -xe;
         l.y = -ye;
         l.z = (y >= 0) ? PiS30 : -PiS30;
      end else begin
         l.x = xe;
         l.y = ye;
         l.z = '0;
      end
      return l;
   endfunction

   function automatic q2e_lane_type q2e_micro(input q2e_lane_type l, input int stage);
      q2e_lane_type r;
      logic signed [LaneW-1:0] x;
      logic signed [LaneW-1:0] y;
      logic signed [LaneW-1:0] xs;
      logic signed [LaneW-1:0] ys;
      x  = l.x;
      y  = l.y;
      xs = x >>> stage;
      ys = y >>> stage;
      if (y >= 0) begin
         r.x = x + ys;
         r.y = y - xs;
         r.z = l.z + q2e_atan(stage);
      end else begin
         r.x = x - ys;
         r.y = y + xs;
         r.z = l.z - q2e_atan(stage);
      end
      return r;
   endfunction

   // round half up to Q3.12, then saturate to +/-lim
   function automatic logic signed [OutW-1:0] q2e_round(input logic signed [AngW-1:0] z,
                                                        input logic signed [OutW-1:0] lim);
      logic signed [AngW-1:0] t;
      logic signed [AngW-19:0] a;
      logic signed [AngW-19:0] le;
      t  = z + AngW'(1 << 17);
      a  = t[AngW-1:18];
      le = (AngW-18)'(lim);
      if (a > le) a = le;
      if (a < -le) a = -le;
      return OutW'(a);
   endfunction

endpackage
`default_nettype wire

/* rtl/q2e_if.sv */
`default_nettype none
interface q2e_req_if import q2e_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [QuatW-1:0] quat_w;
   logic signed [QuatW-1:0] quat_x;
   logic signed [QuatW-1:0] quat_y;
   logic signed [QuatW-1:0] quat_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_rsp_if import q2e_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [RollW-1:0]  roll_angle;
   logic signed [PitchW-1:0] pitch_angle;
   logic signed [RollW-1:0]  yaw_angle;
   logic                     pitch_clamped;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   output ready);
endinterface
`default_nettype wire

/* rtl/quaternion_to_euler_angles.sv */
// Quaternion to ZYX Euler angles.
// req_if carries one quaternion (quat_w/x/y/z, signed Q2.14) per item;
// rsp_if returns roll_angle, pitch_angle, yaw_angle (signed Q3.12 radians)
// and pitch_clamped, set when |2(wy - zx)| reaches one.
// Both channels use valid/ready; an item moves when both are high.
// One item is accepted every cycle while the output is not stalled. From
// acceptance to rsp valid, an item passes the product, sum and radicand
// registers, 29 square root cells that form the pitch cosine one root bit
// each, one quadrant fold, one CORDIC cell per stage and the output register.
// The whole pipeline advances together; while rsp valid is high and ready
// low, every stage holds and req ready drops, and the pending result stays
// stable. Synchronous reset clears all valid bits; no item is in flight
// after reset and the block keeps no other state.
`default_nettype none
module quaternion_to_euler_angles import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = 14
) (
   input  logic        clock,
   input  logic        reset,
   q2e_req_if.sink     req_if,
   q2e_rsp_if.source   rsp_if
);

   localparam int Stages = (CORDIC_STAGES > AtanEntries) ? AtanEntries : CORDIC_STAGES;

   logic advance;

   // product stage
   logic                       p_valid_ff;
   logic signed [2*QuatW-1:0]  wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   // sum stage
   logic                    s_valid_ff;
   logic signed [SumW-1:0]  sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;
   logic signed [SumW-1:0]  sr_in, cr_in, sp_in, sy_in, cy_in, sp_abs;
   logic                    clamp_ff, clamp_in;
   logic [MagW-1:0]         mag_ff;
   logic [2*MagW-1:0]       mag_sq;

   q2e_sq_type sq_link [SqrtSteps+1];
   q2e_sq_type s3_in;
   q2e_cd_type cd_link [Stages+1];
   q2e_cd_type pre_in;
   q2e_cd_type pre_ff;
   q2e_sq_type sq_last;
   q2e_cd_type cd_last;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [RollW-1:0]  roll_ff, roll_in;
   logic signed [PitchW-1:0] pitch_ff, pitch_in;
   logic signed [RollW-1:0]  yaw_ff, yaw_in;
   logic                     flag_ff, flag_in;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= req_if.valid;
         wx_ff <= req_if.quat_w * req_if.quat_x;
         yz_ff <= req_if.quat_y * req_if.quat_z;
         xx_ff <= req_if.quat_x * req_if.quat_x;
         yy_ff <= req_if.quat_y * req_if.quat_y;
         wy_ff <= req_if.quat_w * req_if.quat_y;
         zx_ff <= req_if.quat_z * req_if.quat_x;
         wz_ff <= req_if.quat_w * req_if.quat_z;
         xy_ff <= req_if.quat_x * req_if.quat_y;
         zz_ff <= req_if.quat_z * req_if.quat_z;
      end
   end

   always_comb begin
      sr_in    = (SumW'(wx_ff) + SumW'(yz_ff)) <<< 1;
      cr_in    = OneS28 - ((SumW'(xx_ff) + SumW'(yy_ff)) <<< 1);
      sp_in    = (SumW'(wy_ff) - SumW'(zx_ff)) <<< 1;
      sy_in    = (SumW'(wz_ff) + SumW'(xy_ff)) <<< 1;
      cy_in    = OneS28 - ((SumW'(yy_ff) + SumW'(zz_ff)) <<< 1);
      clamp_in = (sp_in >= OneS28) || (sp_in <= -OneS28);
      sp_abs   = sp_in[SumW-1] ? -sp_in : sp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (advance) begin
         s_valid_ff <= p_valid_ff;
         sr_ff      <= sr_in;
         cr_ff      <= cr_in;
         sp_ff      <= sp_in;
         sy_ff      <= sy_in;
         cy_ff      <= cy_in;
         clamp_ff   <= clamp_in;
         mag_ff     <= sp_abs[MagW-1:0];
      end
   end

   assign mag_sq = mag_ff * mag_ff;

   // radicand 2^56 - s*s; garbage when clamped, result is overridden then
   always_comb begin
      s3_in         = '0;
      s3_in.valid   = s_valid_ff;
      s3_in.sr      = sr_ff;
      s3_in.cr      = cr_ff;
      s3_in.sp      = sp_ff;
      s3_in.sy      = sy_ff;
      s3_in.cy      = cy_ff;
      s3_in.clamped = clamp_ff;
      s3_in.n       = {1'b0, 57'(57'd1 << 56) - 57'(mag_sq)};
   end

   q2e_sq_type s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_ff <= s3_in;
      end
   end

   assign sq_link[0] = s3_ff;

   for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .sq_in   (sq_link[i]),
         .sq_out  (sq_link[i+1])
      );
   end

   assign sq_last = sq_link[SqrtSteps];

   always_comb begin
      pre_in           = '0;
      pre_in.valid     = sq_last.valid;
      pre_in.roll      = q2e_prerotate(sq_last.sr, sq_last.cr);
      pre_in.pitch     = q2e_prerotate(sq_last.sp, SumW'(sq_last.root));
      pre_in.yaw       = q2e_prerotate(sq_last.sy, sq_last.cy);
      pre_in.roll_zero = (sq_last.sr == '0) && (sq_last.cr == '0);
      pre_in.yaw_zero  = (sq_last.sy == '0) && (sq_last.cy == '0);
      pre_in.clamped   = sq_last.clamped;
      pre_in.pitch_neg = sq_last.sp[SumW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff.valid <= 1'b0;
      end else if (advance) begin
         pre_ff <= pre_in;
      end
   end

   assign cd_link[0] = pre_ff;

   for (genvar i = 0; i < Stages; i++) begin : g_cordic
      q2e_cordic_cell #(.STAGE(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cd_in   (cd_link[i]),
         .cd_out  (cd_link[i+1])
      );
   end

   assign cd_last = cd_link[Stages];

   always_comb begin
      rsp_valid_in = advance ? cd_last.valid : rsp_valid_ff;
      roll_in  = cd_last.roll_zero ? '0 : RollW'(q2e_round(cd_last.roll.z, AngleMax));
      yaw_in   = cd_last.yaw_zero ? '0 : RollW'(q2e_round(cd_last.yaw.z, AngleMax));
      flag_in  = cd_last.clamped;
      if (cd_last.clamped) begin
         pitch_in = cd_last.pitch_neg ? -PitchW'(HalfPiQ12) : PitchW'(HalfPiQ12);
      end else begin
         pitch_in = PitchW'(q2e_round(cd_last.pitch.z, HalfPiQ12));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         flag_ff  <= flag_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.roll_angle    = roll_ff;
   assign rsp_if.pitch_angle   = pitch_ff;
   assign rsp_if.yaw_angle     = yaw_ff;
   assign rsp_if.pitch_clamped = flag_ff;

endmodule
`default_nettype wire

/* rtl/q2e_sqrt_cell.sv */
`default_nettype none
module q2e_sqrt_cell import q2e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  q2e_sq_type sq_in,
   output q2e_sq_type sq_out
);

   q2e_sq_type         cell_in;
   q2e_sq_type         cell_ff;
   logic [SqRemW-1:0]  r2;
   logic [SqRemW-1:0]  trial;

   // one root bit per cell: bring down two operand bits, try to subtract
   always_comb begin
      cell_in = sq_in;
      r2      = {sq_in.rem[SqRemW-3:0], sq_in.n[SqNW-1 -: 2]};
      trial   = SqRemW'({sq_in.root, 2'b01});
      cell_in.n = {sq_in.n[SqNW-3:0], 2'b00};
      if (r2 >= trial) begin
         cell_in.rem  = r2 - trial;
         cell_in.root = {sq_in.root[SqRootW-2:0], 1'b1};
      end else begin
         cell_in.rem  = r2;
         cell_in.root = {sq_in.root[SqRootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign sq_out = cell_ff;

endmodule
`default_nettype wire

/* rtl/q2e_cordic_cell.sv */
`default_nettype none
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  q2e_cd_type cd_in,
   output q2e_cd_type cd_out
);

   q2e_cd_type cell_in;
   q2e_cd_type cell_ff;

   // one micro-rotation on each of the three lanes
   always_comb begin
      cell_in       = cd_in;
      cell_in.roll  = q2e_micro(cd_in.roll, STAGE);
      cell_in.pitch = q2e_micro(cd_in.pitch, STAGE);
      cell_in.yaw   = q2e_micro(cd_in.yaw, STAGE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cd_out = cell_ff;

endmodule
`default_nettype wire

/* rtl/q2e_checker.sv */
`default_nettype none
`include "quaternion_to_euler_angles_assert.svh"
module q2e_checker import q2e_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [RollW-1:0]  roll_angle,
   input logic signed [PitchW-1:0] pitch_angle,
   input logic signed [RollW-1:0]  yaw_angle,
   input logic                     pitch_clamped
);

   `Q2E_ASSERT_NEXT_RST(a_reset_empty, reset, !rsp_valid, "rsp valid after reset")
   `Q2E_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(roll_angle) && $stable(pitch_angle) && $stable(yaw_angle),
      "stalled item changed")
   `Q2E_ASSERT_ALWAYS(a_clamp_pitch, !(rsp_valid && pitch_clamped) ||
      pitch_angle == 14'sd6434 || pitch_angle == -14'sd6434, "clamped pitch not pi/2")
   `Q2E_ASSERT_ALWAYS(a_range, !rsp_valid || (roll_angle <= 15'sd12868 &&
      roll_angle >= -15'sd12868 && yaw_angle <= 15'sd12868 && yaw_angle >= -15'sd12868 &&
      pitch_angle <= 14'sd6434 && pitch_angle >= -14'sd6434), "angle out of range")
   `Q2E_ASSERT_ALWAYS(a_ready_link, req_ready == (!rsp_valid || rsp_ready),
      "input taken while output stalled")

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .roll_angle    (rsp_if.roll_angle),
   .pitch_angle   (rsp_if.pitch_angle),
   .yaw_angle     (rsp_if.yaw_angle),
   .pitch_clamped (rsp_if.pitch_clamped)
);
`default_nettype wire

/* verif/q2e_tb_if.sv */
`timescale 1ns / 100ps
// The block's channel interfaces live in rtl/q2e_if.sv; nothing extra is needed here.
package q2e_tb_types;
   typedef struct packed {
      logic signed [14:0] roll;
      logic signed [13:0] pitch;
      logic signed [14:0] yaw;
      logic               clamped;
   } euler_type;
endpackage

/* verif/tb_quaternion_to_euler_angles.sv */
`timescale 1ns / 100ps
module tb_quaternion_to_euler_angles;
   import q2e_pkg::*;
   import q2e_tb_types::*;

   localparam int Stages = 14;
   localparam longint TurnS30 = 64'sd3373259426;
   localparam longint OneS28 = 64'sd268435456;
   localparam int Limit = 400000;

   logic clock;
   logic reset;
   q2e_req_if req_if ();
   q2e_rsp_if rsp_if ();

   quaternion_to_euler_angles #(.CORDIC_STAGES(Stages)) dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if)
   );

   euler_type angles_due[$];
   int mismatches = 0;
   int results_seen = 0;
   int clamps_seen = 0;
   int cycle = 0;
   int send_idle = 34;
   int recv_idle = 82;
   int hold_off = 0;
   bit sending_done = 0;

   longint arc_table[20] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
      8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
      16383, 8191, 4095, 2047};

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - r - b;
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint vector_angle(longint y, longint x, longint lim);
      longint z, a, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? TurnS30 : -TurnS30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < Stages && i < 20; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + arc_table[i];
         end else begin
            x = x - ys; y = y + xs; z = z - arc_table[i];
         end
      end
      a = floor_shift(z + (64'sd1 <<< 17), 18);
      if (a > lim) a = lim;
      if (a < -lim) a = -lim;
      return a;
   endfunction

   function automatic euler_type predict_angles(logic signed [15:0] qw,
         logic signed [15:0] qx, logic signed [15:0] qy, logic signed [15:0] qz);
      euler_type e;
      longint w, x, y, z, sr, cr, sp, sy, cy, c;
      w = qw; x = qx; y = qy; z = qz;
      sr = 2 * (w * x + y * z);
      cr = OneS28 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = OneS28 - 2 * (y * y + z * z);
      e.roll = 15'(vector_angle(sr, cr, 12868));
      e.yaw = 15'(vector_angle(sy, cy, 12868));
      if (sp >= OneS28 || sp <= -OneS28) begin
         e.pitch = (sp > 0) ? 14'sd6434 : -14'sd6434;
         e.clamped = 1'b1;
      end else begin
         c = int_sqrt(OneS28 * OneS28 - sp * sp);
         e.pitch = 14'(vector_angle(sp, c, 6434));
         e.clamped = 1'b0;
      end
      return e;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > Limit) begin
         $display("timeout after %0d cycles", cycle);
         $display("[quaternion_to_euler_angles] ERROR");
         $finish;
      end
   end

   // directed rows; the expectation is typed in where it is obvious
   typedef struct {
      logic signed [15:0] w, x, y, z;
      bit known;
      euler_type e;
   } row_type;

   row_type rows[$];

   task automatic add_row(int w, int x, int y, int z, bit known = 0,
         int r = 0, int p = 0, int yw = 0, bit cl = 0);
      row_type rw;
      rw.w = 16'(w); rw.x = 16'(x); rw.y = 16'(y); rw.z = 16'(z);
      rw.known = known;
      rw.e.roll = 15'(r); rw.e.pitch = 14'(p); rw.e.yaw = 15'(yw); rw.e.clamped = cl;
      rows.push_back(rw);
   endtask

   task automatic send_item(logic signed [15:0] w, logic signed [15:0] x,
         logic signed [15:0] y, logic signed [15:0] z, bit known, euler_type e);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 0;
         @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.quat_w <= w; req_if.quat_x <= x; req_if.quat_y <= y; req_if.quat_z <= z;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      angles_due.push_back(known ? e : predict_angles(w, x, y, z));
      @(negedge clock);
   endtask

   task automatic send_random(int n);
      logic signed [15:0] q[4];
      int k;
      euler_type none;
      none = '0;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         for (int j = 0; j < 4; j++) begin
            if (k < 6) q[j] = 16'($signed($urandom_range(16384 * 2)) - 16384) >>> 1;
            else if (k < 8) q[j] = 16'($urandom);
            else q[j] = 16'($urandom_range(3) * 16383 - 16383 * (j % 2));
         end
         send_item(q[0], q[1], q[2], q[3], 0, none);
      end
   endtask

   initial begin
      req_if.valid = 0;
      req_if.quat_w = 0; req_if.quat_x = 0; req_if.quat_y = 0; req_if.quat_z = 0;
      add_row(0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(16384, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(11585, 0, 11585, 0);
      add_row(11585, 0, -11585, 0);
      add_row(16384, 0, 16384, 0);
      add_row(16384, 0, -16384, 0);
      add_row(0, 16384, 0, 0);
      add_row(0, 0, 0, 16384);
      add_row(11585, 11585, 0, 0);
      add_row(11585, 0, 0, -11585);
      add_row(32767, 32767, 32767, 32767);
      add_row(-32768, -32768, -32768, -32768);
      add_row(-32768, 32767, -32768, 32767);
      add_row(32767, -32768, 0, 0);
      add_row(0, 0, 16384, 0);
      add_row(8192, 8192, 8192, 8192);
      add_row(8192, -8192, 8192, -8192);
      add_row(0, 11585, 0, 11585);
      add_row(16383, 1, -1, 0);
      add_row(-1, -1, -1, -1);
      add_row(21845, 0, 0, 0);
      @(negedge clock);
      while (reset) @(negedge clock);
      foreach (rows[i]) send_item(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                                  rows[i].known, rows[i].e);
      send_random(450);
      send_idle = 82; recv_idle = 34;
      send_random(450);
      send_idle = 0; recv_idle = 0;
      hold_off = 300;
      send_random(500);
      req_if.valid <= 0;
      sending_done = 1;
   end

   // receiver: random stalls plus one long hold-off to back the pipe up
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      euler_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.roll = rsp_if.roll_angle;
         got.pitch = rsp_if.pitch_angle;
         got.yaw = rsp_if.yaw_angle;
         got.clamped = rsp_if.pitch_clamped;
         results_seen++;
         if (got.clamped) clamps_seen++;
         if (angles_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = angles_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0d: expected %p got %p", cycle, want, got);
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      while (angles_due.size() != 0) @(posedge clock);
      repeat (Stages + 60) @(posedge clock);
      $display("checked %0d angle sets, %0d at gimbal lock, under three stall mixes",
               results_seen, clamps_seen);
      if (mismatches == 0 && angles_due.size() == 0) begin
         $display("[quaternion_to_euler_angles] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[quaternion_to_euler_angles] ERROR");
      end
      $finish;
   end
endmodule

/* quaternion_to_euler_angles.f */
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_if.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_angles.sv
rtl/q2e_checker.sv
verif/q2e_tb_if.sv
verif/tb_quaternion_to_euler_angles.sv
